[design/tcb_pkg.sv]
// Shared types and constants for the text cell buffer.
`timescale 1ns / 1ps
`default_nettype none
package tcb_pkg;

    // Default geometry limits of the cell store.
    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 64;

    // Width of column and row counts (holds up to 511).
    localparam int CW = 9;
    // Width of linear indexes and products of two counts.
    localparam int IW = 2 * CW;
    // One cell: glyph, attribute, foreground and background color.
    localparam int CELL_W = 96;

    // Configuration register indexes.
    localparam logic CFG_COLUMNS   = 1'b0;
    localparam logic CFG_ROW_COUNT = 1'b1;

    // Request kinds.
    typedef enum logic [2:0] {
        REQ_WRITE     = 3'd0,
        REQ_READ_XY   = 3'd1,
        REQ_MOVE_TO   = 3'd2,
        REQ_MOVE_REL  = 3'd3,
        REQ_NEXT_LINE = 3'd4,
        REQ_SCROLL    = 3'd5,
        REQ_CLEAR     = 3'd6,
        REQ_READ_CUR  = 3'd7
    } req_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_SIZE,
        ST_MUL_BASE,
        ST_EXEC,
        ST_DIV,
        ST_CP_RD,
        ST_CP_WR,
        ST_ZERO,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

[design/tcb_ram.sv]
// Generic memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module tcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[design/tcb_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tcb_div
    import tcb_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [IW-1:0] dividend,
    input  wire logic [CW-1:0] divisor,
    output logic               done,
    output logic      [IW-1:0] quotient,
    output logic      [CW-1:0] remainder
);

    localparam int NW = $clog2(IW + 1);

    logic [IW-1:0] quo_reg;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] dvs_reg;
    logic [NW-1:0] cnt_reg;
    logic          busy_reg;
    logic [CW:0]   trial;
    logic          fits;

    // Shift in the next dividend bit and try a subtraction.
    assign trial = {rem_reg, quo_reg[IW-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= NW'(IW);
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[IW-2:0], fits};
            rem_reg <= fits ? CW'(trial - {1'b0, dvs_reg}) : CW'(trial);
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == NW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign done      = !busy_reg && !start;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

[design/text_cell_buffer_with_cursor.sv]
// Top level of the character-cell text buffer with cursor.
`timescale 1ns / 1ps
`default_nettype none
// Character-cell text buffer: one request beat in, one result beat out carrying the
// cursor and, for reads, the cell contents. A small sequencer drives one shared
// 9x9 multiplier (store size, cursor index, row offsets), a bit-serial divider
// and a single cell memory port pair. Each request passes the size and base multiply
// states and an execute state before its result; move-relative adds a division,
// scroll copies cells up and zeroes the vacated rows, and clear zeroes every cell
// in use. After reset the whole store is zeroed before the first request is taken;
// configuration writes are taken at any time the block is idle.
module text_cell_buffer_with_cursor
    import tcb_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Request channel.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // glyph[15:0] attr[31:16] fg_color[63:32] bg_color_in[95:64] x_pos[103:96]
    // y_pos[111:104] steps[126:112] line_count[133:127], zero fill above
    input  wire logic [135:0] s_tdata,
    // req_type[2:0]
    input  wire logic [2:0]   s_tuser,
    // Result channel.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // cursor_col[6:0] cursor_row[12:7] read_glyph[28:13] read_attr[44:29]
    // read_fg[76:45] read_bg[108:77], zero fill above
    output logic      [111:0] m_tdata,
    // Configuration write port.
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [7:0]   cfg_wdata
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    state_t state_reg, state_next;

    logic [7:0]        columns_reg;
    logic [6:0]        rows_cfg_reg;
    logic [XW-1:0]     cur_x_reg;
    logic [YW-1:0]     cur_y_reg;

    // Latched request.
    req_t              req_reg;
    logic [CELL_W-1:0] cell_in_reg;
    logic [7:0]        x_in_reg, y_in_reg;
    logic [14:0]       steps_reg;
    logic [6:0]        lines_reg;

    logic [IW-1:0]     mul_reg, size_reg, base_reg, cur_idx_reg;
    logic [IW-1:0]     k_reg, cp_end_reg, z_end_reg, off_reg, rd_addr_reg;
    logic              rd_flag_reg, init_reg;
    logic [111:0]      out_reg;
    logic              out_valid_reg;

    logic [CW-1:0]     eff_cols, eff_rows, new_cols, new_rows;
    logic [CW-1:0]     mul_a, mul_b;
    logic [CW-1:0]     m_rows, n_lines;
    logic [IW-1:0]     rd_addr_next, ridx;
    logic [IW:0]       rel_sum;
    logic [IW-1:0]     rel_idx;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;
    logic              div_start, div_done;
    logic [IW-1:0]     div_quo;
    logic [CW-1:0]     div_rem;
    logic              accept, out_free;

    // Effective geometry, saturated into the supported range.
    function automatic logic [CW-1:0] sat(input logic [CW-1:0] v, input logic [CW-1:0] hi);
        logic [CW-1:0] r;
        r = (v == '0) ? CW'(1) : v;
        return (r > hi) ? hi : r;
    endfunction

    assign eff_cols = sat(CW'(columns_reg), CW'(MAX_COLS));
    assign eff_rows = sat(CW'(rows_cfg_reg), CW'(MAX_ROWS));
    assign new_cols = (cfg_index == CFG_COLUMNS) ? sat(CW'(cfg_wdata), CW'(MAX_COLS)) : eff_cols;
    assign new_rows = (cfg_index == CFG_ROW_COUNT) ?
                      sat(CW'(cfg_wdata[6:0]), CW'(MAX_ROWS)) : eff_rows;

    // Scroll span: rows above and at the cursor, lines clamped to that span.
    assign m_rows  = CW'(cur_y_reg) + 1'b1;
    assign n_lines = (CW'(lines_reg) > m_rows) ? m_rows : CW'(lines_reg);

    // Read index at x,y, clamped to the last cell in use.
    assign ridx = ((mul_reg + IW'(x_in_reg)) >= size_reg) ? size_reg - 1'b1
                                                          : mul_reg + IW'(x_in_reg);

    // Relative move index, clamped below at zero.
    assign rel_sum = {1'b0, cur_idx_reg} + {{(IW + 1 - 15){steps_reg[14]}}, steps_reg};
    assign rel_idx = rel_sum[IW] ? '0 : rel_sum[IW-1:0];

    assign out_free = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_MUL_SIZE;
            ST_MUL_SIZE: state_next = ST_MUL_BASE;
            ST_MUL_BASE: state_next = ST_EXEC;
            ST_EXEC: begin
                case (req_reg)
                    REQ_MOVE_REL: state_next = ST_DIV;
                    REQ_SCROLL:   state_next = ST_CP_RD;
                    REQ_CLEAR:    state_next = ST_ZERO;
                    default:      state_next = ST_DONE;
                endcase
            end
            ST_DIV:      if (div_done) state_next = ST_DONE;
            ST_CP_RD:    state_next = (k_reg == cp_end_reg) ? ST_ZERO : ST_CP_WR;
            ST_CP_WR:    state_next = ST_CP_RD;
            ST_ZERO: begin
                if (k_reg == z_end_reg) begin
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control outputs: request ready, multiplier operands, memory ports, divider start.
    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        mul_a        = eff_rows;
        mul_b        = eff_cols;
        rd_addr_next = rd_addr_reg;
        ram_we       = 1'b0;
        ram_waddr    = k_reg;
        ram_wdata    = '0;
        div_start    = 1'b0;
        case (state_reg)
            ST_MUL_SIZE: mul_a = CW'(cur_y_reg);
            ST_MUL_BASE: mul_a = (req_reg == REQ_READ_XY) ? CW'(y_in_reg) : n_lines;
            ST_EXEC: begin
                case (req_reg)
                    REQ_WRITE: begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_idx_reg;
                        ram_wdata = cell_in_reg;
                    end
                    REQ_READ_XY:  rd_addr_next = ridx;
                    REQ_READ_CUR: rd_addr_next = cur_idx_reg;
                    REQ_MOVE_REL: div_start = 1'b1;
                    default: ;
                endcase
            end
            ST_CP_RD: rd_addr_next = k_reg + off_reg;
            ST_CP_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            ST_ZERO:     ram_we = (k_reg != z_end_reg);
            default: ;
        endcase
    end

    // Cell store.
    tcb_ram #(
        .WIDTH(CELL_W),
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr[AW-1:0]),
        .wdata(ram_wdata),
        .raddr(rd_addr_next[AW-1:0]),
        .rdata(ram_rdata)
    );

    // Divider that splits the relative index into row and column.
    tcb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rel_idx),
        .divisor  (eff_cols),
        .done     (div_done),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    // Control state: sequencer, geometry, cursor, output beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ZERO;
            init_reg      <= 1'b1;
            k_reg         <= '0;
            z_end_reg     <= IW'(DEPTH);
            columns_reg   <= 8'd80;
            rows_cfg_reg  <= 7'd25;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_flag_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Output beat is loaded when done and room is free, else drained.
            if (state_reg == ST_DONE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            // Register write clamps the cursor into the new bounds.
            if (cfg_we) begin
                if (cfg_index == CFG_COLUMNS) columns_reg <= cfg_wdata;
                else rows_cfg_reg <= cfg_wdata[6:0];
                if (CW'(cur_x_reg) >= new_cols) cur_x_reg <= XW'(new_cols - 1'b1);
                if (CW'(cur_y_reg) >= new_rows) cur_y_reg <= YW'(new_rows - 1'b1);
            end

            case (state_reg)
                ST_IDLE: rd_flag_reg <= 1'b0;
                ST_EXEC: begin
                    case (req_reg)
                        REQ_READ_XY, REQ_READ_CUR: rd_flag_reg <= 1'b1;
                        REQ_MOVE_TO: begin
                            cur_x_reg <= (CW'(x_in_reg) >= eff_cols) ?
                                         XW'(eff_cols - 1'b1) : XW'(x_in_reg);
                            cur_y_reg <= (CW'(y_in_reg) >= eff_rows) ?
                                         YW'(eff_rows - 1'b1) : YW'(y_in_reg);
                        end
                        REQ_NEXT_LINE: begin
                            cur_x_reg <= '0;
                            cur_y_reg <= (m_rows >= eff_rows) ?
                                         YW'(eff_rows - 1'b1) : YW'(m_rows);
                        end
                        REQ_SCROLL: begin
                            k_reg      <= '0;
                            off_reg    <= mul_reg;
                            cp_end_reg <= base_reg + IW'(eff_cols) - mul_reg;
                            z_end_reg  <= base_reg + IW'(eff_cols);
                        end
                        REQ_CLEAR: begin
                            k_reg     <= '0;
                            z_end_reg <= size_reg;
                        end
                        default: ;
                    endcase
                end
                ST_DIV: begin
                    if (div_done) begin
                        cur_x_reg <= XW'(div_rem);
                        cur_y_reg <= (div_quo >= IW'(eff_rows)) ?
                                     YW'(eff_rows - 1'b1) : YW'(div_quo);
                    end
                end
                ST_CP_WR: k_reg <= k_reg + 1'b1;
                ST_ZERO: begin
                    if (k_reg != z_end_reg) k_reg <= k_reg + 1'b1;
                    else init_reg <= 1'b0;
                end
                ST_DONE: begin
                    if (out_free) begin
                        out_reg <= {3'b000,
                                    rd_flag_reg ? ram_rdata : {CELL_W{1'b0}},
                                    6'(cur_y_reg), 7'(cur_x_reg)};
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers: latched request and shared multiplier results.
    always_ff @(posedge aclk) begin
        mul_reg     <= IW'(mul_a * mul_b);
        rd_addr_reg <= rd_addr_next;
        if (accept) begin
            req_reg     <= req_t'(s_tuser);
            cell_in_reg <= s_tdata[95:0];
            x_in_reg    <= s_tdata[103:96];
            y_in_reg    <= s_tdata[111:104];
            steps_reg   <= s_tdata[126:112];
            lines_reg   <= s_tdata[133:127];
        end
        if (state_reg == ST_MUL_SIZE) size_reg <= mul_reg;
        if (state_reg == ST_MUL_BASE) begin
            base_reg    <= mul_reg;
            cur_idx_reg <= mul_reg + IW'(cur_x_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule
`default_nettype wire
